[rtl/core/lct_pkg.sv]
// shared types, codes and field widths of the caching lock table
package lct_pkg;

	// default sizing of the top level parameters
	localparam int NUM_LOCKS_DEF   = 1024;
	localparam int NUM_CLIENTS_DEF = 16;

	// fixed field widths of the request and response transactions
	localparam int LOCK_W    = 10;
	localparam int CLIENT_W  = 4;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	// response tdata bit positions
	localparam int M_STATUS_LO  = 0;
	localparam int M_REVOKE_BIT = 2;
	localparam int M_RVCL_LO    = 3;
	localparam int M_RETRY_BIT  = 7;
	localparam int M_RTCL_LO    = 8;

	// request kinds carried in tuser
	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// per-lock status
	typedef enum logic [1:0] {
		LS_FREE     = 2'd0,
		LS_LOCKED   = 2'd1,
		LS_WAIT     = 2'd2,
		LS_RETRYING = 2'd3
	} lock_state_t;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		RES_OK    = 2'd0,
		RES_RETRY = 2'd1,
		RES_IOERR = 2'd2
	} result_t;

	// controller states
	typedef enum logic [1:0] {
		CS_CLEAR = 2'd0,
		CS_IDLE  = 2'd1,
		CS_EXEC  = 2'd2
	} ctl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic exec;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

[rtl/core/lct_ram.sv]
// generic single write port, single read port ram with registered read
module lct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/lct_ctrl.sv]
// controller state machine: clearing pass, request capture, read-modify-write
module lct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  lct_pkg::stat_t stat,
	output lct_pkg::cmd_t  cmd
);

	lct_pkg::ctl_state_t state_q;
	lct_pkg::ctl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lct_pkg::CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.clear_wr = 1'b0;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			lct_pkg::CS_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = lct_pkg::CS_IDLE;
				end
			end
			lct_pkg::CS_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = lct_pkg::CS_EXEC;
				end
			end
			lct_pkg::CS_EXEC: begin
				cmd.exec = stat.out_free;
				if (stat.out_free) begin
					state_d = lct_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = lct_pkg::CS_CLEAR;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a captured request is always followed by its execute cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == lct_pkg::CS_EXEC)
		else $error("capture not followed by execute state");

	// commands are mutually exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.capture, cmd.exec}))
		else $error("overlapping datapath commands");

	// the clearing pass only ends on its last entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lct_pkg::CS_CLEAR && !stat.clear_last) |=> state_q == lct_pkg::CS_CLEAR)
		else $error("clearing pass left early");
`endif

endmodule

[rtl/core/lct_dp.sv]
// datapath: request registers, table ram, entry update and response register
module lct_dp #(
	parameter int NUM_LOCKS   = lct_pkg::NUM_LOCKS_DEF,
	parameter int NUM_CLIENTS = lct_pkg::NUM_CLIENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lct_pkg::S_TDATA_W-1:0] s_tdata,   // lock_index[9:0], client_index[13:10]
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lct_pkg::M_TDATA_W-1:0] m_tdata,   // status[1:0], send_revoke[2],
	                                                 // revoke_client[6:3], send_retry[7],
	                                                 // retry_client[11:8]
	input  lct_pkg::cmd_t                 cmd,
	output lct_pkg::stat_t                stat
);

	localparam int AW      = $clog2(NUM_LOCKS);
	localparam int CW      = lct_pkg::CLIENT_W;
	localparam int ENTRY_W = NUM_CLIENTS + CW + 2;

	// lowest set bit of the waiter mask, truncated to the client field
	function automatic logic [CW-1:0] lowest_waiter(input logic [NUM_CLIENTS-1:0] mask);
		logic [CW-1:0] idx;
		idx = '0;
		for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = CW'(i);
			end
		end
		return idx;
	endfunction

	logic [lct_pkg::LOCK_W-1:0] in_lock;
	logic [CW-1:0]              in_client;
	logic                       in_ok;

	logic                       kind_q;
	logic [AW-1:0]              addr_q;
	logic [CW-1:0]              cl_q;
	logic                       ok_q;
	logic [AW-1:0]              clr_addr_q;

	logic [ENTRY_W-1:0]         rdata;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [ENTRY_W-1:0]         wdata;

	lct_pkg::lock_state_t       rd_st;
	logic [CW-1:0]              rd_own;
	logic [NUM_CLIENTS-1:0]     rd_wt;
	logic [NUM_CLIENTS-1:0]     cl_bit;
	logic [NUM_CLIENTS-1:0]     wt_less;

	lct_pkg::lock_state_t       nx_st;
	logic [CW-1:0]              nx_own;
	logic [NUM_CLIENTS-1:0]     nx_wt;
	lct_pkg::result_t           res;
	logic                       rv;
	logic [CW-1:0]              rv_cl;
	logic                       rt;
	logic [CW-1:0]              rt_cl;

	logic                       m_tvalid_q;
	logic [lct_pkg::M_TDATA_W-1:0] m_tdata_q;

	// request field decode and range check
	assign in_lock   = s_tdata[lct_pkg::LOCK_W-1:0];
	assign in_client = s_tdata[lct_pkg::LOCK_W +: CW];
	assign in_ok     = (32'(in_lock) < NUM_LOCKS) && (32'(in_client) < NUM_CLIENTS);

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= s_tuser;
			addr_q <= AW'(in_lock);
			cl_q   <= in_client;
			ok_q   <= in_ok;
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign stat.clear_last = (clr_addr_q == AW'(NUM_LOCKS - 1));
	assign stat.out_free   = !m_tvalid_q || m_tready;

	// lock table
	lct_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_LOCKS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.capture),
		.raddr(AW'(in_lock)),
		.rdata(rdata)
	);

	// entry fields
	assign rd_st   = lct_pkg::lock_state_t'(rdata[1:0]);
	assign rd_own  = rdata[2 +: CW];
	assign rd_wt   = rdata[ENTRY_W-1 -: NUM_CLIENTS];
	assign cl_bit  = NUM_CLIENTS'(1) << cl_q;
	assign wt_less = rd_wt & ~cl_bit;

	// entry update and response
	always_comb begin
		nx_st  = rd_st;
		nx_own = rd_own;
		nx_wt  = rd_wt;
		res    = lct_pkg::RES_OK;
		rv     = 1'b0;
		rv_cl  = '0;
		rt     = 1'b0;
		rt_cl  = '0;
		if (!ok_q) begin
			res = lct_pkg::RES_IOERR;
		end else if (kind_q == lct_pkg::KIND_ACQUIRE) begin
			case (rd_st)
				lct_pkg::LS_FREE: begin
					nx_st  = lct_pkg::LS_LOCKED;
					nx_own = cl_q;
				end
				lct_pkg::LS_LOCKED: begin
					nx_st = lct_pkg::LS_WAIT;
					nx_wt = rd_wt | cl_bit;
					rv    = 1'b1;
					rv_cl = rd_own;
					res   = lct_pkg::RES_RETRY;
				end
				lct_pkg::LS_WAIT: begin
					nx_wt = rd_wt | cl_bit;
					res   = lct_pkg::RES_RETRY;
				end
				default: begin
					// retrying: a waiter takes the lock, anyone else queues
					if ((rd_wt & cl_bit) != '0) begin
						nx_wt  = wt_less;
						nx_own = cl_q;
						if (wt_less != '0) begin
							nx_st = lct_pkg::LS_WAIT;
							rv    = 1'b1;
							rv_cl = cl_q;
						end else begin
							nx_st = lct_pkg::LS_LOCKED;
						end
					end else begin
						nx_wt = rd_wt | cl_bit;
						res   = lct_pkg::RES_RETRY;
					end
				end
			endcase
		end else begin
			case (rd_st)
				lct_pkg::LS_LOCKED: begin
					nx_st  = lct_pkg::LS_FREE;
					nx_own = '0;
				end
				lct_pkg::LS_WAIT: begin
					nx_st  = lct_pkg::LS_RETRYING;
					nx_own = '0;
					if (rd_wt != '0) begin
						rt    = 1'b1;
						rt_cl = lowest_waiter(rd_wt);
					end
				end
				default: begin
					res = lct_pkg::RES_IOERR;
				end
			endcase
		end
	end

	// table write port: clearing sweep or entry write-back
	assign we    = cmd.clear_wr || (cmd.exec && ok_q);
	assign waddr = cmd.clear_wr ? clr_addr_q : addr_q;
	assign wdata = cmd.clear_wr ? '0 : {nx_wt, nx_own, nx_st};

	// response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= cmd.exec || (m_tvalid_q && !m_tready);
		end
	end

	// response register payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			m_tdata_q <= {4'b0, rt_cl, rt, rv_cl, rv, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/caching_lock_table.sv]
// Lock table top level: one request at a time, each a read-modify-write of one table entry.
// An accepted request is registered with its table read, then executed and its response
// registered; the next request is accepted only after the write-back of the table RAM.
// A response waiting on m_tready holds the next request in its execute cycle only.
// Reset: asynchronous, active low; afterwards a clearing pass over all NUM_LOCKS entries
// sets every lock free before s_tready is first raised.
module caching_lock_table #(
	parameter int NUM_LOCKS   = lct_pkg::NUM_LOCKS_DEF,
	parameter int NUM_CLIENTS = lct_pkg::NUM_CLIENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lct_pkg::S_TDATA_W-1:0] s_tdata,   // lock_index[9:0], client_index[13:10]
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lct_pkg::M_TDATA_W-1:0] m_tdata    // status[1:0], send_revoke[2],
	                                                 // revoke_client[6:3], send_retry[7],
	                                                 // retry_client[11:8]
);

	lct_pkg::cmd_t  cmd;
	lct_pkg::stat_t stat;

	// controller
	lct_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath
	lct_dp #(
		.NUM_LOCKS  (NUM_LOCKS),
		.NUM_CLIENTS(NUM_CLIENTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

`ifndef SYNTHESIS
	// one request in flight: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("back-to-back request accepted");

	// every executed request leaves a response pending
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("executed request produced no response");

	// a retry message only comes with an ok release
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[lct_pkg::M_RETRY_BIT]) |->
		m_tdata[lct_pkg::M_STATUS_LO +: lct_pkg::STATUS_W] == lct_pkg::RES_OK)
		else $error("retry message with non-ok status");

	// an error response carries no messages
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[lct_pkg::M_STATUS_LO +: lct_pkg::STATUS_W] == lct_pkg::RES_IOERR)
		|-> !m_tdata[lct_pkg::M_REVOKE_BIT] && !m_tdata[lct_pkg::M_RETRY_BIT])
		else $error("error response with a message");
`endif

endmodule

[tb/caching_lock_table_test.sv]
// testbench for the caching lock table: directed and random lock requests checked against a predictor
module caching_lock_table_test;
	import lct_pkg::*;

	localparam int NUM_LOCKS   = NUM_LOCKS_DEF;
	localparam int NUM_CLIENTS = NUM_CLIENTS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;

	// one response transaction, as the predictor works it out
	typedef struct packed {
		result_t             status;
		logic                revoke;
		logic [CLIENT_W-1:0] revoke_client;
		logic                retry;
		logic [CLIENT_W-1:0] retry_client;
	} lock_reply_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // lock_index[9:0], client_index[13:10]
	logic                 s_tuser  = 1'b0; // kind
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // status[1:0], send_revoke[2], revoke_client[6:3],
	                                       // send_retry[7], retry_client[11:8]

	// predicted table contents
	lock_state_t          lock_state [NUM_LOCKS];
	logic [CLIENT_W-1:0]  lock_holder [NUM_LOCKS];
	logic [NUM_CLIENTS-1:0] lock_queue [NUM_LOCKS];

	lock_reply_t pending_replies [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          tx_idle_pct    = 0;
	int          rx_idle_pct    = 0;
	int          holds_asked    = 0;
	int          holds_taken    = 0;

	caching_lock_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// applies one request to the predicted table and returns the response it causes
	function automatic lock_reply_t lock_table_update(input logic kind,
			input logic [LOCK_W-1:0] idx, input logic [CLIENT_W-1:0] client);
		lock_reply_t            r;
		logic [NUM_CLIENTS-1:0] me;
		r = '{status: RES_OK, revoke: 1'b0, revoke_client: '0, retry: 1'b0, retry_client: '0};
		me = '0;
		me[client] = 1'b1;
		if (kind == KIND_ACQUIRE) begin
			case (lock_state[idx])
				LS_FREE: begin
					lock_state[idx]  = LS_LOCKED;
					lock_holder[idx] = client;
				end
				LS_LOCKED: begin
					// first contender: revoke goes to the holder, even if it asks itself
					lock_state[idx]  = LS_WAIT;
					lock_queue[idx] |= me;
					r.revoke         = 1'b1;
					r.revoke_client  = lock_holder[idx];
					r.status         = RES_RETRY;
				end
				LS_WAIT: begin
					lock_queue[idx] |= me;
					r.status         = RES_RETRY;
				end
				default: begin
					if ((lock_queue[idx] & me) != '0) begin
						// a waiter takes the lock; others still queued get it revoked at once
						lock_queue[idx] &= ~me;
						lock_holder[idx] = client;
						if (lock_queue[idx] != '0) begin
							lock_state[idx] = LS_WAIT;
							r.revoke        = 1'b1;
							r.revoke_client = client;
						end else begin
							lock_state[idx] = LS_LOCKED;
						end
					end else begin
						lock_queue[idx] |= me;
						r.status         = RES_RETRY;
					end
				end
			endcase
		end else begin
			case (lock_state[idx])
				LS_LOCKED: begin
					lock_state[idx]  = LS_FREE;
					lock_holder[idx] = '0;
				end
				LS_WAIT: begin
					// waiters stay queued; the lowest one is told to retry
					lock_state[idx]  = LS_RETRYING;
					lock_holder[idx] = '0;
					if (lock_queue[idx] != '0) begin
						r.retry = 1'b1;
						for (int c = NUM_CLIENTS - 1; c >= 0; c--)
							if (lock_queue[idx][c])
								r.retry_client = CLIENT_W'(c);
					end
				end
				default: r.status = RES_IOERR;
			endcase
		end
		return r;
	endfunction

	// offers one request, waits for its transaction and records the expected response
	task automatic send_request(input logic kind, input logic [LOCK_W-1:0] idx,
			input logic [CLIENT_W-1:0] client);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - LOCK_W - CLIENT_W){1'b0}}, client, idx};
		do
			@(posedge clk);
		while (!s_tready);
		pending_replies.push_back(lock_table_update(kind, idx, client));
	endtask

	// receiver side: random back-pressure, plus long hold-offs when asked
	initial begin
		forever begin
			@(posedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic report_field(input string field, input int want, input int got);
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		mismatch_count++;
	endtask

	// response checker
	always @(posedge clk) begin : check_replies
		lock_reply_t want;
		lock_reply_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status        = result_t'(m_tdata[M_STATUS_LO +: STATUS_W]);
			got.revoke        = m_tdata[M_REVOKE_BIT];
			got.revoke_client = m_tdata[M_RVCL_LO +: CLIENT_W];
			got.retry         = m_tdata[M_RETRY_BIT];
			got.retry_client  = m_tdata[M_RTCL_LO +: CLIENT_W];
			if (pending_replies.size() == 0) begin
				$display("%0t: response with none expected, actual tdata %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status != want.status)
					report_field("status", int'(want.status), int'(got.status));
				if (got.revoke != want.revoke)
					report_field("send_revoke", int'(want.revoke), int'(got.revoke));
				if (got.revoke_client != want.revoke_client)
					report_field("revoke_client", int'(want.revoke_client),
						int'(got.revoke_client));
				if (got.retry != want.retry)
					report_field("send_retry", int'(want.retry), int'(got.retry));
				if (got.retry_client != want.retry_client)
					report_field("retry_client", int'(want.retry_client),
						int'(got.retry_client));
			end
		end
	end

	// grant and release at the extremes, release of a free lock, release by a non-owner
	task automatic test_grant_release();
		send_request(KIND_ACQUIRE, 10'd0, 4'd0);
		send_request(KIND_RELEASE, 10'd0, 4'd0);
		send_request(KIND_RELEASE, 10'd0, 4'd0);
		send_request(KIND_ACQUIRE, 10'd1023, 4'd15);
		send_request(KIND_RELEASE, 10'd1023, 4'd3);
		send_request(KIND_RELEASE, 10'd700, 4'd15);
	endtask

	// contention: revoke to holder, owner asking again, retry to lowest waiter, hand-over
	task automatic test_contention();
		send_request(KIND_ACQUIRE, 10'd341, 4'd2);
		send_request(KIND_ACQUIRE, 10'd341, 4'd2);
		send_request(KIND_ACQUIRE, 10'd341, 4'd9);
		send_request(KIND_ACQUIRE, 10'd341, 4'd4);
		send_request(KIND_RELEASE, 10'd341, 4'd0);
		send_request(KIND_RELEASE, 10'd341, 4'd0);
		send_request(KIND_ACQUIRE, 10'd341, 4'd7);
		send_request(KIND_ACQUIRE, 10'd341, 4'd4);
		send_request(KIND_RELEASE, 10'd341, 4'd4);
		send_request(KIND_ACQUIRE, 10'd341, 4'd2);
		send_request(KIND_RELEASE, 10'd341, 4'd2);
		send_request(KIND_ACQUIRE, 10'd341, 4'd7);
		send_request(KIND_RELEASE, 10'd341, 4'd7);
		send_request(KIND_ACQUIRE, 10'd341, 4'd9);
		send_request(KIND_RELEASE, 10'd341, 4'd9);
		send_request(KIND_RELEASE, 10'd341, 4'd9);
	endtask

	// random traffic, mostly on a few busy locks so that every lock state is reached
	task automatic test_random_traffic(input int items, input int tx_pct, input int rx_pct);
		logic [LOCK_W-1:0]   busy [4];
		logic [LOCK_W-1:0]   idx;
		logic [CLIENT_W-1:0] client;
		logic                kind;
		int                  n;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		foreach (busy[i])
			busy[i] = LOCK_W'($urandom_range(NUM_LOCKS - 1));
		for (n = 0; n < items; n++) begin
			if ($urandom_range(99) < 85)
				idx = busy[2'($urandom_range(3))];
			else
				idx = LOCK_W'($urandom_range(NUM_LOCKS - 1));
			if ($urandom_range(1))
				client = CLIENT_W'($urandom_range(3));
			else
				client = CLIENT_W'($urandom_range(NUM_CLIENTS - 1));
			kind = ($urandom_range(99) < 35) ? KIND_RELEASE : KIND_ACQUIRE;
			send_request(kind, idx, client);
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_back_pressure();
		int n;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		holds_asked++;
		for (n = 0; n < 40; n++)
			send_request(($urandom_range(99) < 35) ? KIND_RELEASE : KIND_ACQUIRE,
				10'd512 + LOCK_W'($urandom_range(1)),
				CLIENT_W'($urandom_range(NUM_CLIENTS - 1)));
	endtask

	// test sequence
	initial begin
		foreach (lock_state[i]) begin
			lock_state[i]  = LS_FREE;
			lock_holder[i] = '0;
			lock_queue[i]  = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_grant_release();
		test_contention();
		test_random_traffic(360, 13, 45);
		test_random_traffic(360, 45, 13);
		test_random_traffic(360, 0, 0);
		test_back_pressure();

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
